@@ sv/csvt_pkg.sv @@
package csvt_pkg;

  localparam logic [7:0] QUOTE_BYTE   = 8'h22;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  localparam logic [7:0] SEPARATOR_RESET   = 8'd44;
  localparam logic [7:0] FIELD_LIMIT_RESET = 8'd0;

  localparam int MAX_FIELDS_DEFAULT = 255;
  localparam int QUEUE_DEPTH        = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_LIMIT = 2'd1;

  // Event codes on the result channel.
  localparam logic [1:0] EV_DATA   = 2'd0;
  localparam logic [1:0] EV_FIELD  = 2'd1;
  localparam logic [1:0] EV_RECORD = 2'd2;

  // What the front end decided a byte does.
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_FIELD  = 2'd2,
    KIND_RECORD = 2'd3
  } kind_t;

  // One queue entry: the result the byte causes, and whether end of input
  // adds a record close behind it.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       eoi_rec;
  } entry_t;

endpackage

@@ sv/csvt_if.sv @@
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] event_res;
  logic [7:0] field_number;
  logic       count_error;
  logic       last;

  modport source (output valid, output out_byte, output event_res, output field_number,
                  output count_error, output last, input ready);
  modport sink (input valid, input out_byte, input event_res, input field_number,
                input count_error, input last, output ready);
endinterface

interface csvt_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/csvt_queue.sv @@
module csvt_queue
  import csvt_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t pop_data,
  output logic   full,
  output logic   empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  entry_t        mem [QUEUE_DEPTH];
  logic [AW:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]   rd_ptr_r, rd_ptr_nxt;

  assign empty    = (wr_ptr_r == rd_ptr_r);
  assign full     = (wr_ptr_r[AW] != rd_ptr_r[AW]) && (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign pop_data = mem[rd_ptr_r[AW-1:0]];

  assign wr_ptr_nxt = wr_ptr_r + (AW+1)'(push);
  assign rd_ptr_nxt = rd_ptr_r + (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r[AW-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue read while empty");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) <= (AW+1)'(QUEUE_DEPTH))
    else $error("queue fill level out of range");

endmodule

@@ sv/csvt_front.sv @@
module csvt_front
  import csvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  csvt_in_if.sink    in_ch,
  input  logic [7:0] separator,
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_data
);

  logic   in_quotes_r, in_quotes_nxt;
  logic   pending_r, pending_nxt;
  logic   accept;
  logic   consumed;
  kind_t  kind;
  logic   eoi_rec;
  logic [7:0] b;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  always_comb begin
    in_quotes_nxt = in_quotes_r;
    pending_nxt   = pending_r;
    consumed      = 1'b0;
    kind          = KIND_NONE;
    eoi_rec       = 1'b0;

    // A pending quote followed by a quote is a literal quote; any other byte
    // closes the quotes and is then handled as unquoted text.
    if (pending_r) begin
      pending_nxt = 1'b0;
      if (b == QUOTE_BYTE) begin
        kind     = KIND_DATA;
        consumed = 1'b1;
      end else begin
        in_quotes_nxt = 1'b0;
      end
    end

    if (!consumed) begin
      if (in_quotes_nxt) begin
        if (b == QUOTE_BYTE) begin
          pending_nxt = 1'b1;
        end else begin
          kind = KIND_DATA;
        end
      end else if (b == NEWLINE_BYTE) begin
        kind = KIND_RECORD;
      end else if (b == QUOTE_BYTE) begin
        in_quotes_nxt = 1'b1;
      end else if (b == separator) begin
        kind = KIND_FIELD;
      end else begin
        kind = KIND_DATA;
      end
    end

    if (in_ch.end_of_input) begin
      eoi_rec       = (kind != KIND_RECORD);
      in_quotes_nxt = 1'b0;
      pending_nxt   = 1'b0;
    end
  end

  assign q_push         = accept && ((kind != KIND_NONE) || eoi_rec);
  assign q_data.kind    = kind;
  assign q_data.data    = b;
  assign q_data.eoi_rec = eoi_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r <= 1'b0;
      pending_r   <= 1'b0;
    end else if (accept) begin
      in_quotes_r <= in_quotes_nxt;
      pending_r   <= pending_nxt;
    end
  end

  a_pending_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> in_quotes_r)
    else $error("quote pending outside quoted mode");
  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.end_of_input) |=> (!in_quotes_r && !pending_r))
    else $error("quote state survives end of input");
  a_eoi_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.end_of_input) |-> q_push)
    else $error("end of input produced no record close");

endmodule

@@ sv/csvt_back.sv @@
module csvt_back
  import csvt_pkg::*;
#(
  parameter int MAX_FIELDS = MAX_FIELDS_DEFAULT
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  entry_t     q_data,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic [7:0] field_limit,
  csvt_out_if.source out_ch
);

  localparam logic [7:0] FIELD_CAP = (MAX_FIELDS > 255) ? 8'd255 : 8'(MAX_FIELDS);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic [1:0] event_r, event_nxt;
  logic [7:0] field_num_r, field_num_nxt;
  logic       count_err_r, count_err_nxt;
  logic       last_r, last_nxt;
  logic       second_r, second_nxt;
  logic [7:0] field_cnt_r, field_cnt_nxt;
  logic       load;
  logic       emit;
  kind_t      emit_kind;
  logic [8:0] count_plus1;

  assign load        = !out_valid_r || out_ch.ready;
  assign count_plus1 = {1'b0, field_cnt_r} + 9'd1;

  always_comb begin
    q_pop      = 1'b0;
    second_nxt = second_r;
    emit       = 1'b0;
    emit_kind  = KIND_NONE;
    last_nxt   = 1'b1;
    if (load) begin
      if (second_r) begin
        // Record close left over from an end-of-input beat.
        emit       = 1'b1;
        emit_kind  = KIND_RECORD;
        second_nxt = 1'b0;
      end else if (!q_empty) begin
        q_pop = 1'b1;
        emit  = 1'b1;
        if (q_data.kind == KIND_NONE) begin
          emit_kind = KIND_RECORD;
        end else begin
          emit_kind  = q_data.kind;
          last_nxt   = !q_data.eoi_rec;
          second_nxt = q_data.eoi_rec;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    event_nxt     = event_r;
    field_num_nxt = field_num_r;
    count_err_nxt = count_err_r;
    field_cnt_nxt = field_cnt_r;
    if (load) begin
      out_valid_nxt = emit;
      out_byte_nxt  = 8'd0;
      field_num_nxt = field_cnt_r;
      count_err_nxt = 1'b0;
      case (emit_kind)
        KIND_DATA: begin
          out_byte_nxt = second_r ? QUOTE_BYTE : q_data.data;
          event_nxt    = EV_DATA;
        end
        KIND_FIELD: begin
          event_nxt = EV_FIELD;
          if (field_cnt_r < FIELD_CAP) begin
            field_cnt_nxt = field_cnt_r + 8'd1;
          end
        end
        KIND_RECORD: begin
          event_nxt     = EV_RECORD;
          count_err_nxt = (field_limit != 8'd0) && (count_plus1 != {1'b0, field_limit});
          field_cnt_nxt = 8'd0;
        end
        default: begin
          event_nxt = EV_DATA;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
      field_cnt_r <= 8'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
      field_cnt_r <= field_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r  <= out_byte_nxt;
      event_r     <= event_nxt;
      field_num_r <= field_num_nxt;
      count_err_r <= count_err_nxt;
      last_r      <= last_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.event_res    = event_r;
  assign out_ch.field_number = field_num_r;
  assign out_ch.count_error  = count_err_r;
  assign out_ch.last         = last_r;

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n) field_cnt_r <= FIELD_CAP)
    else $error("field counter above its cap");
  a_second_valid: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> (out_valid_r && !last_r))
    else $error("second result held without a first in the output register");
  a_record_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && emit && emit_kind == KIND_RECORD) |=> (field_cnt_r == 8'd0))
    else $error("record close left the field counter set");
  a_err_on_record: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && count_err_r) |-> (event_r == EV_RECORD))
    else $error("count error on a non-record result");

endmodule

@@ sv/csv_field_tokenizer_top.sv @@
// Data path: an accepted byte is written into the queue; the back end loads
// its first result into the output register, and a second result follows.
// Throughput: one byte per cycle unless the queue is full; a byte with two
// results is absorbed by the four-entry queue between front and back end.
// Reset: rst_n, synchronous, active low; clears quote state, field counter,
// queue and output valid, and sets separator to comma and field limit to 0.
module csv_field_tokenizer_top
  import csvt_pkg::*;
#(
  parameter int MAX_FIELDS = MAX_FIELDS_DEFAULT
)
(
  input  logic       clk,
  input  logic       rst_n,
  csvt_in_if.sink    in_if,
  csvt_out_if.source out_if,
  csvt_cfg_if.sink   cfg_if
);

  logic [7:0] separator_r;
  logic [7:0] field_limit_r;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  entry_t     q_wdata;
  entry_t     q_rdata;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      separator_r   <= SEPARATOR_RESET;
      field_limit_r <= FIELD_LIMIT_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_SEPARATOR:   separator_r   <= cfg_if.data;
        REG_FIELD_LIMIT: field_limit_r <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  csvt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .separator (separator_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  csvt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  csvt_back #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_data      (q_rdata),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .field_limit (field_limit_r),
    .out_ch      (out_if)
  );

endmodule
